// ===== hdl/khc_pkg.sv =====
package khc_pkg;

  localparam int unsigned NUM_KEYS   = 16;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned HOLD_W     = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd800;
  localparam logic [KEY_W-1:0]  KEY_LAST   = 4'd15;

  // Key phase codes; code 3 is unused and leaves a key untouched
  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;

  // Event kinds
  localparam logic EV_PRESS = 1'b0;
  localparam logic EV_HOLD  = 1'b1;

  // Physical key index to logical key id (label digit) through the 4x4 remap
  localparam logic [KEY_W-1:0] LOGICAL_OF_PHYS [NUM_KEYS] = '{
    4'd12, 4'd8,  4'd4, 4'd0,
    4'd13, 4'd9,  4'd5, 4'd1,
    4'd14, 4'd10, 4'd6, 4'd2,
    4'd15, 4'd11, 4'd7, 4'd3
  };

  typedef struct packed {
    logic [1:0]         phase;
    logic [STAMP_W-1:0] stamp;
  } key_state_t;

  typedef struct packed {
    key_state_t upd;
    logic       ev;
    logic       kind;
  } key_eval_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } seq_state_t;

endpackage

// ===== hdl/khc_cell.sv =====
// One slot of the key state ring; passes its contents on every step
module khc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  khc_pkg::key_state_t din,
  output khc_pkg::key_state_t dout
);
  import khc_pkg::*;

  key_state_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

// ===== hdl/khc_eval.sv =====
// Per-key phase update for the key at the head of the ring
module khc_eval (
  input  logic                              cur_pressed,
  input  logic [khc_pkg::STAMP_W-1:0]       now,
  input  logic [khc_pkg::HOLD_W-1:0]        hold,
  input  khc_pkg::key_state_t               cur,
  output khc_pkg::key_eval_t                res
);
  import khc_pkg::*;

  logic [STAMP_W-1:0] elapsed;
  logic               hold_hit;

  // Elapsed time wraps modulo 2^32
  assign elapsed  = now - cur.stamp;
  assign hold_hit = elapsed >= {{(STAMP_W-HOLD_W){1'b0}}, hold};

  always_comb begin
    res.upd  = cur;
    res.ev   = 1'b0;
    res.kind = EV_PRESS;
    case (cur.phase)
      PH_RELEASED: begin
        if (cur_pressed) begin
          res.upd.phase = PH_PRESSED;
          res.upd.stamp = now;
        end
      end
      PH_PRESSED: begin
        if (cur_pressed) begin
          if (hold_hit) begin
            res.upd.phase = PH_HELD;
            res.upd.stamp = now;
            res.ev        = 1'b1;
            res.kind      = EV_HOLD;
          end
        end else begin
          res.upd.phase = PH_RELEASED;
          res.upd.stamp = now;
          res.ev        = 1'b1;
          res.kind      = EV_PRESS;
        end
      end
      PH_HELD: begin
        if (!cur_pressed) begin
          res.upd.phase = PH_RELEASED;
          res.upd.stamp = now;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/keypad_press_hold_classifier.sv =====
// A poll is scanned one key per cycle, the walk pausing while an event waits on
// a stalled output, then a flush state sends its last event; a new poll is
// accepted only after that. The single rotating ring of 16 key cells with one
// update unit sets this pace.
// Reset (rst, synchronous): all keys released with zero stamps, hold 800 ms,
// output empty, input ready.
module keypad_press_hold_classifier (
  input  logic        clk,
  input  logic        rst,
  // poll beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] pressed_bits, [47:16] time_now_ms
  // event beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] key_id, [7:4] zero
  output logic [0:0]  m_tuser,   // [0] event_kind
  output logic        m_tlast,   // last_event
  // hold duration register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import khc_pkg::*;

  seq_state_t state, state_next;

  logic [KEY_W-1:0]    step;
  logic [NUM_KEYS-1:0] bits_sr;
  logic [STAMP_W-1:0]  now_r;
  logic [HOLD_W-1:0]   hold_r;

  logic                pend_valid;
  logic [KEY_W-1:0]    pend_key;
  logic                pend_kind;

  logic [KEY_W-1:0]    out_key;
  logic                out_kind;
  logic                out_last;

  logic out_free, advance, push_mid, push_last, in_beat;

  key_state_t ring [NUM_KEYS];
  key_eval_t  head_eval;

  // Ring of key cells; the head is the key being visited
  genvar gi;
  generate
    for (gi = 0; gi < NUM_KEYS; gi++) begin : g_cell
      if (gi == NUM_KEYS - 1) begin : g_tail
        khc_cell u_cell (
          .clk  (clk),
          .rst  (rst),
          .shift(advance),
          .din  (head_eval.upd),
          .dout (ring[gi])
        );
      end else begin : g_body
        khc_cell u_cell (
          .clk  (clk),
          .rst  (rst),
          .shift(advance),
          .din  (ring[gi+1]),
          .dout (ring[gi])
        );
      end
    end
  endgenerate

  khc_eval u_eval (
    .cur_pressed(bits_sr[0]),
    .now        (now_r),
    .hold       (hold_r),
    .cur        (ring[0]),
    .res        (head_eval)
  );

  // Handshake and step control
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    in_beat   = s_tvalid && s_tready;
    out_free  = !m_tvalid || m_tready;
    advance   = (state == ST_SCAN) && (!head_eval.ev || !pend_valid || out_free);
    push_mid  = advance && head_eval.ev && pend_valid;
    push_last = (state == ST_FLUSH) && pend_valid && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:  if (advance && step == KEY_LAST) state_next = ST_FLUSH;
      ST_FLUSH: if (!pend_valid || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_r <= cfg_data;
    end
  end

  // Poll capture and key walk
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (in_beat) begin
      step    <= '0;
      bits_sr <= s_tdata[15:0];
      now_r   <= s_tdata[47:16];
    end else if (advance) begin
      step    <= step + 1'b1;
      bits_sr <= bits_sr >> 1;
    end
  end

  // Pending event; held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (advance && head_eval.ev) begin
      pend_valid <= 1'b1;
      pend_key   <= LOGICAL_OF_PHYS[step];
      pend_kind  <= head_eval.kind;
    end else if (push_last) begin
      pend_valid <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_mid || push_last) begin
      m_tvalid <= 1'b1;
      out_key  <= pend_key;
      out_kind <= pend_kind;
      out_last <= push_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0000, out_key};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// ===== hdl/khc_checker.sv =====
module khc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  // A stalled event beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("event beat changed while stalled");

  // One poll at a time: busy right after a poll beat
  a_busy_after_poll: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("poll accepted while previous poll in progress");

  // A non-final event means the poll is still being worked on
  a_nonlast_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("idle with a poll's events unfinished");

  // Reset leaves an empty output and a ready input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind keypad_press_hold_classifier khc_checker u_khc_checker (.*);
